// ===== hw/rtl/sojb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sojb_pkg
// Shared sizes, beat types and cell control for the ordered jitter buffer.
// ----------------------------------------------------------------------------
package sojb_pkg;

    localparam int DEPTH    = 16;
    localparam int SEQ_BITS = 32;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int FILL_W   = 5;
    localparam int CMP_W    = (CNT_W > FILL_W) ? CNT_W : FILL_W;
    localparam int ADDR_W   = 3;

    localparam logic [FILL_W-1:0] MIN_FILL_RST = FILL_W'(4);

    // register word index taken from the byte address
    localparam logic REG_MIN_FILL = 1'b0;

    localparam logic OP_INSERT   = 1'b0;
    localparam logic OP_RETRIEVE = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [31:0] seq_in;
        logic [31:0] time_in;
        logic [15:0] payload_in;
    } t_sojb_in;

    typedef struct packed {
        logic              frame_valid;
        logic [31:0]       seq_out;
        logic [31:0]       time_out;
        logic [15:0]       payload_out;
        logic              dropped;
        logic              playback_start;
        logic [FILL_W-1:0] fill_level;
    } t_sojb_out;

    typedef struct packed {
        logic [SEQ_BITS-1:0] seq;
        logic [31:0]         tstamp;
        logic [15:0]         payload;
    } t_sojb_entry;

    typedef struct packed {
        logic                insert;
        logic                pop;
        logic [SEQ_BITS-1:0] seq;
    } t_sojb_ctl;

endpackage

// ===== hw/rtl/sequence_ordered_jitter_buffer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequence_ordered_jitter_buffer_top
// Frame store ordered by sequence number with insert and retrieve beats.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall / i_in_data) carries one operation
// per beat: insert a frame or retrieve the lowest-numbered one. Every input
// beat yields exactly one output beat (o_out_valid / i_out_stall / o_out_data)
// holding the retrieved frame or a not-valid flag, the drop flag, the
// one-time playback-start pulse and the fill after the operation.
// The result is registered: it sits in the output register on the cycle after
// the accepted input beat. The block takes one operation per cycle while
// o_in_stall is low; all cells of the chain compare against the new sequence
// number in parallel and shift together, so the chain does the whole insert or pop.
// While the receiver stalls, the held result stays and o_in_stall is raised,
// so at most one result waits. Synchronous reset empties the store (count
// zero), re-arms playback start and sets playback_min_fill to 4. The min-fill
// register is at APB byte address 0; write it only while idle (not enforced).
// ----------------------------------------------------------------------------
module sequence_ordered_jitter_buffer_top
    import sojb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_sojb_in          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_sojb_out         o_out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [FILL_W-1:0] r_min_fill;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_begun;
    logic              n_begun;
    logic              r_out_valid;
    t_sojb_out         r_out_data;
    t_sojb_out         n_out_data;
    t_sojb_ctl         w_ctl;
    t_sojb_entry       w_new;
    t_sojb_entry       w_head;
    logic              w_accept;
    logic              w_full;
    logic              w_empty;
    logic              w_reg_sel;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_full     = r_count == CNT_W'(DEPTH);
    assign w_empty    = r_count == '0;

    assign w_new.seq     = i_in_data.seq_in[SEQ_BITS-1:0];
    assign w_new.tstamp  = i_in_data.time_in;
    assign w_new.payload = i_in_data.payload_in;

    assign w_ctl.seq    = w_new.seq;
    assign w_ctl.insert = w_accept && (i_in_data.opcode == OP_INSERT) && !w_full;
    assign w_ctl.pop    = w_accept && (i_in_data.opcode == OP_RETRIEVE) && !w_empty;

    sojb_chain u_chain (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_new   (w_new),
        .i_count (r_count),
        .o_head  (w_head)
    );

    always_comb begin
        n_count    = r_count;
        n_begun    = r_begun;
        n_out_data = '0;
        if (w_ctl.insert) begin
            n_count = r_count + CNT_W'(1);
            if (!r_begun && (CMP_W'(n_count) >= CMP_W'(r_min_fill))) begin
                n_begun                   = 1'b1;
                n_out_data.playback_start = 1'b1;
            end
        end else if (w_ctl.pop) begin
            n_count                = r_count - CNT_W'(1);
            n_out_data.frame_valid = 1'b1;
            n_out_data.seq_out     = 32'(w_head.seq);
            n_out_data.time_out    = w_head.tstamp;
            n_out_data.payload_out = w_head.payload;
        end
        if (i_in_data.opcode == OP_INSERT && w_full) begin
            n_out_data.dropped = 1'b1;
        end
        n_out_data.fill_level = FILL_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_begun     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_begun     <= n_begun;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // config port, register word index in paddr[2]
    assign w_reg_sel = paddr[2] == REG_MIN_FILL;
    assign pready    = 1'b1;
    assign prdata    = w_reg_sel ? 32'(r_min_fill) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_fill <= MIN_FILL_RST;
        end else if (psel && penable && pwrite && pready && w_reg_sel) begin
            r_min_fill <= pwdata[FILL_W-1:0];
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("fill count beyond depth");

    a_start_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_begun |=> r_begun)
        else $error("playback start re-armed");

    a_start_not_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.playback_start |-> !o_out_data.frame_valid)
        else $error("playback start on a retrieve beat");

    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_in_data.opcode == OP_RETRIEVE && w_empty
        |=> !o_out_data.frame_valid && o_out_data.fill_level == '0)
        else $error("retrieve from empty store returned a frame");

    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_in_data.opcode == OP_INSERT && w_full |=> $stable(r_count))
        else $error("dropped insert changed the fill");

endmodule

// ===== hw/rtl/sojb_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sojb_cell
// One slot of the ordered store: keeps, takes the new frame, or shifts.
// ----------------------------------------------------------------------------
module sojb_cell
    import sojb_pkg::*;
(
    input  logic        i_clk,
    input  t_sojb_ctl   i_ctl,
    input  t_sojb_entry i_new,
    input  t_sojb_entry i_left,
    input  logic        i_left_lt,
    input  t_sojb_entry i_right,
    input  logic        i_occ,
    output t_sojb_entry o_entry,
    output logic        o_lt
);

    t_sojb_entry r_entry;
    t_sojb_entry n_entry;

    assign o_lt    = i_occ && (r_entry.seq < i_ctl.seq);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.insert) begin
            // smaller entries stay put, the first non-smaller slot takes the frame
            if (!o_lt) begin
                n_entry = i_left_lt ? i_new : i_left;
            end
        end else if (i_ctl.pop) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// ===== hw/rtl/sojb_chain.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sojb_chain
// Row of DEPTH cells kept sorted by sequence number, head at cell 0.
// ----------------------------------------------------------------------------
module sojb_chain
    import sojb_pkg::*;
(
    input  logic             i_clk,
    input  t_sojb_ctl        i_ctl,
    input  t_sojb_entry      i_new,
    input  logic [CNT_W-1:0] i_count,
    output t_sojb_entry      o_head
);

    t_sojb_entry w_entry [DEPTH];
    logic        w_lt    [DEPTH];

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            t_sojb_entry w_left;
            t_sojb_entry w_right;
            logic        w_left_lt;
            logic        w_occ;

            if (gi == 0) begin : g_first
                assign w_left    = i_new;
                assign w_left_lt = 1'b1;
            end else begin : g_mid
                assign w_left    = w_entry[gi-1];
                assign w_left_lt = w_lt[gi-1];
            end

            if (gi == DEPTH - 1) begin : g_last
                assign w_right = w_entry[gi];
            end else begin : g_inner
                assign w_right = w_entry[gi+1];
            end

            assign w_occ = CNT_W'(gi) < i_count;

            sojb_cell u_cell (
                .i_clk     (i_clk),
                .i_ctl     (i_ctl),
                .i_new     (i_new),
                .i_left    (w_left),
                .i_left_lt (w_left_lt),
                .i_right   (w_right),
                .i_occ     (w_occ),
                .o_entry   (w_entry[gi]),
                .o_lt      (w_lt[gi])
            );
        end
    endgenerate

    assign o_head = w_entry[0];

endmodule

// ===== tb/sojb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sojb_checker
// Watches the beat channels and the register port of the ordered jitter
// buffer, keeps its own ordered frame store and compares every result beat
// field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module sojb_checker
    import sojb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  t_sojb_in          i_in_data,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  t_sojb_out         i_out_data,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [ADDR_W-1:0] i_paddr,
    input  logic [31:0]       i_pwdata,
    input  logic              i_pready,
    output int                o_fail_count,
    output int                o_pending
);

    t_sojb_entry       frames [DEPTH];
    int                frame_count;
    logic              playback_begun;
    logic [FILL_W-1:0] min_fill;
    t_sojb_out         expected_results [$];
    t_sojb_out         want;
    int                fail_count = 0;

    // one operation on the predicted store, returns the result it causes
    function automatic t_sojb_out apply_frame_op(t_sojb_in op);
        t_sojb_out   res;
        t_sojb_entry fr;
        int          pos;
        res = '0;
        if (op.opcode == OP_INSERT) begin
            if (frame_count >= DEPTH) begin
                res.dropped = 1'b1;
            end else begin
                fr.seq     = op.seq_in[SEQ_BITS-1:0];
                fr.tstamp  = op.time_in;
                fr.payload = op.payload_in;
                // new frame goes right after the last smaller number
                pos = 0;
                for (int i = 0; i < frame_count; i++) begin
                    if (frames[i].seq < fr.seq) begin
                        pos = i + 1;
                    end
                end
                for (int i = frame_count; i > pos; i--) begin
                    frames[i] = frames[i-1];
                end
                frames[pos] = fr;
                frame_count++;
                if (!playback_begun && frame_count >= min_fill) begin
                    playback_begun     = 1'b1;
                    res.playback_start = 1'b1;
                end
            end
        end else if (frame_count > 0) begin
            res.frame_valid = 1'b1;
            res.seq_out     = 32'(frames[0].seq);
            res.time_out    = frames[0].tstamp;
            res.payload_out = frames[0].payload;
            for (int i = 1; i < frame_count; i++) begin
                frames[i-1] = frames[i];
            end
            frame_count--;
        end
        res.fill_level = FILL_W'(frame_count);
        return res;
    endfunction

    task automatic check_field(string what, logic [31:0] exp_val, logic [31:0] act_val);
        if (exp_val !== act_val) begin
            fail_count++;
            $display("%0t sojb_checker: %s expected 0x%08h actual 0x%08h",
                     $time, what, exp_val, act_val);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frame_count    = 0;
            playback_begun = 1'b0;
            min_fill       = MIN_FILL_RST;
            expected_results.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready &&
                i_paddr[ADDR_W-1:2] == REG_MIN_FILL) begin
                min_fill = i_pwdata[FILL_W-1:0];
            end
            // result beat belongs to an earlier input beat, so check before pushing
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    fail_count++;
                    $display("%0t sojb_checker: result beat expected none actual 0x%h",
                             $time, i_out_data);
                end else begin
                    want = expected_results[0];
                    expected_results.delete(0);
                    check_field("frame_valid", 32'(want.frame_valid),
                                32'(i_out_data.frame_valid));
                    check_field("seq_out", want.seq_out, i_out_data.seq_out);
                    check_field("time_out", want.time_out, i_out_data.time_out);
                    check_field("payload_out", 32'(want.payload_out),
                                32'(i_out_data.payload_out));
                    check_field("dropped", 32'(want.dropped), 32'(i_out_data.dropped));
                    check_field("playback_start", 32'(want.playback_start),
                                32'(i_out_data.playback_start));
                    check_field("fill_level", 32'(want.fill_level),
                                32'(i_out_data.fill_level));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_results.push_back(apply_frame_op(i_in_data));
            end
        end
        o_fail_count = fail_count;
        o_pending    = expected_results.size();
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the ordered jitter buffer with a directed fill, drop and partial drain run,
// then random insert and retrieve traffic over several playback thresholds,
// with random idling on both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
    import sojb_pkg::*;

    localparam int WATCHDOG_CYCLES = 2000;
    localparam int HOLD_CYCLES     = 64;
    localparam int PHASE_OPS       = 220;
    localparam int NUM_PHASES      = 5;
    localparam logic [ADDR_W-1:0] MIN_FILL_ADDR = ADDR_W'({REG_MIN_FILL, 2'b00});

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_stall;
    t_sojb_in          i_in_data   = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    t_sojb_out         o_out_data;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [ADDR_W-1:0] paddr       = '0;
    logic [31:0]       pwdata      = '0;
    logic [31:0]       prdata;
    logic              pready;

    int fail_count;
    int pending;
    int quiet_cycles = 0;
    bit idle_on      = 1'b1;
    bit hold_req     = 1'b0;
    bit hold_taken   = 1'b0;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    sequence_ordered_jitter_buffer_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    sojb_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_data   (o_out_data),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // called at a falling edge, returns at the falling edge after the beat
    task automatic send_op(t_sojb_in op);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= op;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic t_sojb_in insert_op(logic [31:0] seq, logic [31:0] stamp,
                                           logic [15:0] handle);
        t_sojb_in op;
        op.opcode     = OP_INSERT;
        op.seq_in     = seq;
        op.time_in    = stamp;
        op.payload_in = handle;
        return op;
    endfunction

    function automatic t_sojb_in random_op(int insert_pct);
        t_sojb_in op;
        op.opcode = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_RETRIEVE;
        case ($urandom_range(0, 3))
            0: begin
                op.seq_in = $urandom_range(0, 7);   // dense numbers, many ties
            end
            1: begin
                op.seq_in = 32'hFFFF_FFF8 + $urandom_range(0, 7);
            end
            default: begin
                op.seq_in = $urandom;
            end
        endcase
        op.time_in    = $urandom;
        op.payload_in = 16'($urandom);
        return op;
    endfunction

    // register writes only once every result is back
    task automatic set_min_fill(logic [FILL_W-1:0] value);
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MIN_FILL_ADDR;
        pwdata  <= 32'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // result side: random stall bursts plus one long hold-off on request
    initial begin
        @(negedge i_clk);
        forever begin
            if (hold_req && !hold_taken) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_taken = 1'b1;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(negedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                @(negedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [31:0]       dir_seq [16];
        logic [FILL_W-1:0] phase_fill [NUM_PHASES];
        int                phase_pct [NUM_PHASES];
        t_sojb_in          op;

        dir_seq = '{32'hFFFF_FFFF, 32'h0, 32'h5, 32'h5, 32'h5, 32'h8000_0000,
                    32'h7FFF_FFFF, 32'h0, 32'h3, 32'hFFFF_FFFF, 32'h1, 32'h6,
                    32'h4, 32'h5, 32'h2, 32'hFFFF_FFFE};
        phase_fill = '{5'd16, 5'd0, FILL_W'($urandom_range(0, 16)), 5'd31, 5'd4};
        phase_pct  = '{55, 50, 65, 45, 50};

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // threshold above the store size: full store never starts playback
        set_min_fill(5'd31);
        op            = '1;
        op.opcode     = OP_RETRIEVE;
        send_op(op);
        for (int i = 0; i < 16; i++) begin
            if (i % 2 == 1) begin
                send_op(insert_op(dir_seq[i], 32'hFFFF_FFFF ^ 32'(i), 16'hFFFF - 16'(i)));
            end else begin
                send_op(insert_op(dir_seq[i], 32'(i), 16'(i)));
            end
        end
        send_op(insert_op(32'h0, 32'hA5A5_A5A5, 16'h5A5A));   // full, dropped
        op        = '0;
        op.opcode = OP_RETRIEVE;
        repeat (4) send_op(op);

        for (int p = 0; p < NUM_PHASES; p++) begin
            set_min_fill(phase_fill[p]);
            if (p == NUM_PHASES - 1) begin
                idle_on = 1'b0;
            end
            for (int n = 0; n < PHASE_OPS; n++) begin
                if (p == 1 && n == 50) begin
                    hold_req = 1'b1;
                end
                send_op(random_op(phase_pct[p]));
            end
        end

        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (5) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
